[hw/rtl/gpi_status_frame_parser_defines.svh]
// Assertion macros used by the status frame parser top level.
`ifndef GPI_STATUS_FRAME_PARSER_DEFINES_SVH
`define GPI_STATUS_FRAME_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define GPI_SFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpi_status_frame_parser: assertion failed");
// Next-cycle implication, disabled while reset is high.
`define GPI_SFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpi_status_frame_parser: assertion failed");
`else
`define GPI_SFP_ASSERT_NOW(label, clk, rst, ante, cons)
`define GPI_SFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/gpi_sfp_pkg.sv]
// Types and constants of the status frame parser.
package gpi_sfp_pkg;

   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int LINE_W = 5;
   localparam int UNIT_W = 4;
   localparam int POS_W  = 6;

   typedef enum logic [OP_W-1:0] {
      OP_RX_BYTE = 2'd0,
      OP_FORCE   = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   localparam logic EV_CHANGE = 1'b0;
   localparam logic EV_POLL   = 1'b1;

   localparam logic [BYTE_W-1:0] CHR_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CHR_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CHR_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CHR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHR_1     = 8'h31;

   localparam logic [POS_W-1:0] POS_IDLE        = 6'd0;
   localparam logic [POS_W-1:0] POS_UNIT        = 6'd1;
   localparam logic [POS_W-1:0] POS_P           = 6'd2;
   localparam logic [POS_W-1:0] POS_COMMA       = 6'd3;
   localparam logic [POS_W-1:0] POS_A           = 6'd4;
   localparam logic [POS_W-1:0] POS_FIRST_DIGIT = 6'd6;
   localparam logic [POS_W-1:0] POS_LAST_COMMA  = 6'd51;
   localparam logic [POS_W-1:0] POS_LAST_DIGIT  = 6'd52;
   localparam logic [POS_W-1:0] POS_FRAME_END   = 6'd53;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [LINE_W-1:0] line;
      logic              level;
   } result_type;

endpackage

[hw/rtl/gpi_sfp_step.sv]
// Single-item step logic: frame position, line levels, masks and the result.
module gpi_sfp_step #(
   parameter int NUM_LINES = 24
) (
   input  logic [gpi_sfp_pkg::OP_W-1:0]   op,
   input  logic [gpi_sfp_pkg::BYTE_W-1:0] rx_byte,
   input  logic [gpi_sfp_pkg::LINE_W-1:0] gpi_index,
   input  logic                           force_level,
   input  logic [gpi_sfp_pkg::UNIT_W-1:0] unit_id,
   input  logic [gpi_sfp_pkg::POS_W-1:0]  pos,
   input  logic [NUM_LINES-1:0]           levels,
   input  logic [NUM_LINES-1:0]           masks,
   output logic [gpi_sfp_pkg::POS_W-1:0]  pos_next,
   output logic [NUM_LINES-1:0]           levels_next,
   output logic [NUM_LINES-1:0]           masks_next,
   output gpi_sfp_pkg::result_type        result
);

   logic [gpi_sfp_pkg::POS_W-1:0]  pos_inc;
   logic [gpi_sfp_pkg::POS_W-1:0]  digit_off;
   logic [gpi_sfp_pkg::LINE_W-1:0] digit_line;
   logic [gpi_sfp_pkg::BYTE_W-1:0] unit_chr;
   logic [NUM_LINES-1:0]           digit_bit;
   logic [NUM_LINES-1:0]           cmd_bit;
   logic                           digit_lvl;
   logic                           is_digit;

   assign pos_inc    = pos + gpi_sfp_pkg::POS_W'(1);
   assign digit_off  = pos - gpi_sfp_pkg::POS_FIRST_DIGIT;
   assign digit_line = digit_off[gpi_sfp_pkg::LINE_W:1];
   assign unit_chr   = gpi_sfp_pkg::CHR_0 + gpi_sfp_pkg::BYTE_W'(unit_id);
   // Shifting past the top leaves zero, so lines beyond the set are never hit.
   assign digit_bit  = NUM_LINES'(1) << digit_line;
   assign cmd_bit    = NUM_LINES'(1) << gpi_index;
   assign digit_lvl  = (rx_byte == gpi_sfp_pkg::CHR_1);
   assign is_digit   = (rx_byte == gpi_sfp_pkg::CHR_0) || (rx_byte == gpi_sfp_pkg::CHR_1);

   always_comb begin
      pos_next    = pos;
      levels_next = levels;
      masks_next  = masks;
      result      = '0;
      unique case (op)
         gpi_sfp_pkg::OP_RX_BYTE: begin
            if (pos == gpi_sfp_pkg::POS_IDLE) begin
               if (rx_byte == gpi_sfp_pkg::CHR_S) pos_next = gpi_sfp_pkg::POS_UNIT;
            end else if (pos == gpi_sfp_pkg::POS_UNIT) begin
               pos_next = (rx_byte == unit_chr) ? pos_inc : gpi_sfp_pkg::POS_IDLE;
            end else if (pos == gpi_sfp_pkg::POS_P) begin
               pos_next = (rx_byte == gpi_sfp_pkg::CHR_P) ? pos_inc : gpi_sfp_pkg::POS_IDLE;
            end else if (pos == gpi_sfp_pkg::POS_COMMA) begin
               pos_next = (rx_byte == gpi_sfp_pkg::CHR_COMMA) ? pos_inc
                                                              : gpi_sfp_pkg::POS_IDLE;
            end else if (pos == gpi_sfp_pkg::POS_A) begin
               pos_next = (rx_byte == gpi_sfp_pkg::CHR_A) ? pos_inc : gpi_sfp_pkg::POS_IDLE;
            end else if ((pos <= gpi_sfp_pkg::POS_LAST_COMMA) && pos[0]) begin
               pos_next = (rx_byte == gpi_sfp_pkg::CHR_COMMA) ? pos_inc
                                                              : gpi_sfp_pkg::POS_IDLE;
            end else if (pos <= gpi_sfp_pkg::POS_LAST_DIGIT) begin
               // bytes other than '0' or '1' hold the position
               if (is_digit) begin
                  pos_next = pos_inc;
                  if ((|digit_bit) && !(|(masks & digit_bit)) &&
                      ((|(levels & digit_bit)) != digit_lvl)) begin
                     levels_next  = digit_lvl ? (levels | digit_bit) : (levels & ~digit_bit);
                     result.valid = 1'b1;
                     result.kind  = gpi_sfp_pkg::EV_CHANGE;
                     result.line  = digit_line;
                     result.level = digit_lvl;
                  end
               end
            end else begin
               pos_next = gpi_sfp_pkg::POS_IDLE;
            end
         end
         gpi_sfp_pkg::OP_FORCE: begin
            if (|cmd_bit) begin
               masks_next = masks | cmd_bit;
               if ((|(levels & cmd_bit)) != force_level) begin
                  levels_next  = force_level ? (levels | cmd_bit) : (levels & ~cmd_bit);
                  result.valid = 1'b1;
                  result.kind  = gpi_sfp_pkg::EV_CHANGE;
                  result.line  = gpi_index;
                  result.level = force_level;
               end
            end
         end
         gpi_sfp_pkg::OP_RELEASE: begin
            if (|cmd_bit) begin
               masks_next   = masks & ~cmd_bit;
               result.valid = 1'b1;
               result.kind  = gpi_sfp_pkg::EV_POLL;
               result.line  = gpi_index;
               result.level = 1'b0;
            end
         end
         default: begin
            // unused operation code: drop the item
         end
      endcase
   end

endmodule

[hw/rtl/gpi_status_frame_parser.sv]
// Top level of the status frame parser: item registers, line state and result register.

// Status frame parser. Each req_ item is either a received serial byte or a force/release
// command for one input line; it yields at most one rsp_ item, either a level change event
// or a status poll request. Items pass through an input register and a result register, so
// the block takes one item per clock cycle unless rsp_ stalls, and a result appears on
// rsp_ from the result register; the combinational step logic between those registers,
// which reads and updates the frame position and the per-line level and mask bits, sets
// that rate. Items that produce no result simply vanish after the step. The input register
// refills while the result register is still waiting, but once both are full req_ready
// stays low for as long as the result is held off. The unit digit matched after 'S' comes
// from the csr_ register, which is always ready; write it only while no item is in flight.
module gpi_status_frame_parser #(
   parameter int NUM_LINES = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gpi_sfp_pkg::UNIT_W-1:0]      csr_unit_id,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gpi_sfp_pkg::OP_W-1:0]        req_operation,
   input  logic [gpi_sfp_pkg::BYTE_W-1:0]      req_rx_byte,
   input  logic [gpi_sfp_pkg::LINE_W-1:0]      req_gpi_index,
   input  logic                                req_force_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_event_kind,
   output logic [gpi_sfp_pkg::LINE_W-1:0]      rsp_event_line,
   output logic                                rsp_new_level
);

`include "gpi_status_frame_parser_defines.svh"

   // input register
   logic                           in_valid_ff;
   logic [gpi_sfp_pkg::OP_W-1:0]   in_op_ff;
   logic [gpi_sfp_pkg::BYTE_W-1:0] in_byte_ff;
   logic [gpi_sfp_pkg::LINE_W-1:0] in_index_ff;
   logic                           in_level_ff;

   // configuration and parser state
   logic [gpi_sfp_pkg::UNIT_W-1:0] unit_id_ff;
   logic [gpi_sfp_pkg::POS_W-1:0]  pos_ff;
   logic [gpi_sfp_pkg::POS_W-1:0]  pos_in;
   logic [NUM_LINES-1:0]           levels_ff;
   logic [NUM_LINES-1:0]           levels_in;
   logic [NUM_LINES-1:0]           masks_ff;
   logic [NUM_LINES-1:0]           masks_in;

   // result register
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   gpi_sfp_pkg::result_type        rsp_ff;
   gpi_sfp_pkg::result_type        step_result;

   logic                           fire;

   // Advance the step whenever the result slot is free or being emptied.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload: load on accept, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff    <= req_operation;
         in_byte_ff  <= req_rx_byte;
         in_index_ff <= req_gpi_index;
         in_level_ff <= req_force_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unit_id_ff <= csr_unit_id;
      end
   end

   gpi_sfp_step #(
      .NUM_LINES (NUM_LINES)
   ) u_step (
      .op          (in_op_ff),
      .rx_byte     (in_byte_ff),
      .gpi_index   (in_index_ff),
      .force_level (in_level_ff),
      .unit_id     (unit_id_ff),
      .pos         (pos_ff),
      .levels      (levels_ff),
      .masks       (masks_ff),
      .pos_next    (pos_in),
      .levels_next (levels_in),
      .masks_next  (masks_in),
      .result      (step_result)
   );

   // Commit the line state only when the step fires.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= gpi_sfp_pkg::POS_IDLE;
         levels_ff <= '0;
         masks_ff  <= '0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         levels_ff <= levels_in;
         masks_ff  <= masks_in;
      end
   end

   // A firing step refills the slot; otherwise drop a taken result.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = step_result.valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_result.valid) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_ff.kind;
   assign rsp_event_line = rsp_ff.line;
   assign rsp_new_level  = rsp_ff.level;

   // The frame position never runs past the frame end.
   `GPI_SFP_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff <= gpi_sfp_pkg::POS_FRAME_END)
   // Line state only moves when a step fires.
   `GPI_SFP_ASSERT_NEXT(a_state_hold, clock, reset, !fire, $stable(levels_ff) && $stable(masks_ff) && $stable(pos_ff))
   // A result only appears after a firing step.
   `GPI_SFP_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(fire))

endmodule
